@@ rtl/gmcp_pkg.sv @@
`default_nettype none
package gmcp_pkg;
  localparam int GRID_MAX_DEF = 128;
  localparam int CFG_W = 8;
  localparam int WGT_W = 4;
  localparam int COST_W = 12;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_START,
    ST_POP,
    ST_POPW,
    ST_RD,
    ST_RDW,
    ST_UPD,
    ST_FIN,
    ST_FINW,
    ST_OUT
  } gmcp_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;
    logic clr_start;
    logic clr_step;
    logic seed;
    logic pop_rd;
    logic pop_take;
    logic nb_rd;
    logic nb_upd;
    logic fin_rd;
    logic fin_take;
    logic run_done;
  } gmcp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic q_empty;
    logic rc_busy;
    logic nb_valid;
    logic nb_last;
  } gmcp_sts_t;
endpackage
`default_nettype wire

@@ rtl/gmcp_ram.sv @@
`default_nettype none
module gmcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/gmcp_ctrl.sv @@
`default_nettype none
module gmcp_ctrl
  import gmcp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last_cell,
  input  wire logic      out_stall,
  input  wire gmcp_sts_t sts,
  output logic           in_stall,
  output logic           out_valid,
  output logic           cfg_ready,
  output gmcp_cmd_t      cmd
);
  gmcp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (in_last_cell) begin
            cmd.clr_start = 1'b1;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_START;
      end
      ST_START: begin
        cmd.seed = 1'b1;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sts.q_empty) state_nxt = ST_FIN;
        else begin
          cmd.pop_rd = 1'b1;
          state_nxt = ST_POPW;
        end
      end
      ST_POPW: begin
        cmd.pop_take = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        // wait for row/col, then read an in-grid neighbor or skip an edge side
        if (sts.rc_busy) state_nxt = ST_RD;
        else if (sts.nb_valid) begin
          cmd.nb_rd = 1'b1;
          state_nxt = ST_RDW;
        end else if (sts.nb_last) state_nxt = ST_POP;
        else cmd.nb_upd = 1'b1;
      end
      ST_RDW: state_nxt = ST_UPD;
      ST_UPD: begin
        cmd.nb_upd = 1'b1;
        state_nxt = sts.nb_last ? ST_POP : ST_RD;
      end
      ST_FIN: begin
        cmd.fin_rd = 1'b1;
        state_nxt = ST_FINW;
      end
      ST_FINW: begin
        cmd.fin_take = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.run_done = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  a_out_only_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT) else $error("out_valid outside output state");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("input open while result pending");
  a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_done |=> state_r == ST_LOAD) else $error("no return to load");
endmodule
`default_nettype wire

@@ rtl/gmcp_dp.sv @@
`default_nettype none
module gmcp_dp
  import gmcp_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic [WGT_W-1:0]  in_cell_weight,
  input  wire gmcp_cmd_t         cmd,
  output gmcp_sts_t              sts,
  output logic [COST_W-1:0]      out_path_cost
);
  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int AW = $clog2(CELLS);
  localparam int SW = $clog2(GRID_MAX + 1);
  localparam int DW = COST_W + 2;  // distance with headroom, all ones = unreached
  localparam logic [DW-1:0] UNR = '1;
  localparam logic [DW-1:0] CMAX = DW'((1 << COST_W) - 1);

  logic [CFG_W-1:0] side_cfg_r;
  logic [SW-1:0]    n_r;
  logic [AW:0]      total_r, load_pos_r, clr_r;
  logic [AW-1:0]    q_head_r, q_tail_r;
  logic [AW-1:0]    q_head_nxt, q_tail_nxt;
  logic [AW:0]      q_cnt_r;
  logic [AW-1:0]    cell_r, nb_r;
  logic [SW-1:0]    row_r, col_r;
  logic [1:0]       dir_r;
  logic [DW-1:0]    cdist_r;
  logic             cd_ld_r;
  logic [COST_W-1:0] cost_r;
  logic             nb_ok_r;
  logic             upd_push;
  logic [AW:0]      total_now;

  // side in use, clamped
  logic [SW-1:0] side_eff;
  always_comb begin
    if (side_cfg_r == '0) side_eff = SW'(1);
    else if (32'(side_cfg_r) > GRID_MAX) side_eff = SW'(GRID_MAX);
    else side_eff = SW'(side_cfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) side_cfg_r <= CFG_W'(1);
    else if (cfg_we) side_cfg_r <= cfg_data;
  end

  // the last-cell item's total uses the current side
  assign total_now = (AW+1)'(side_eff) * (AW+1)'(side_eff);

  // circular queue pointers
  assign q_head_nxt = (q_head_r == AW'(CELLS - 1)) ? '0 : q_head_r + 1'b1;
  assign q_tail_nxt = (q_tail_r == AW'(CELLS - 1)) ? '0 : q_tail_r + 1'b1;

  // memories
  logic           w_we;  logic [AW-1:0] w_wa, w_ra; logic [WGT_W-1:0] w_rd;
  logic           d_we;  logic [AW-1:0] d_wa, d_ra; logic [DW-1:0] d_wd, d_rd;
  logic           m_we;  logic [AW-1:0] m_wa, m_ra; logic m_wd, m_rd;
  logic           q_we;  logic [AW-1:0] q_wa;       logic [AW-1:0] q_wd, q_rd;

  gmcp_ram #(.WIDTH(WGT_W), .DEPTH(CELLS)) u_wgt (.clk, .we(w_we), .waddr(w_wa),
    .wdata(in_cell_weight), .raddr(w_ra), .rdata(w_rd));
  gmcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dist (.clk, .we(d_we), .waddr(d_wa),
    .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  gmcp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark (.clk, .we(m_we), .waddr(m_wa),
    .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  gmcp_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_q (.clk, .we(q_we), .waddr(q_wa),
    .wdata(q_wd), .raddr(q_head_r), .rdata(q_rd));

  // neighbor for current direction: up, down, left, right
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  always_comb begin
    nb_ok = 1'b0; nb_addr = cell_r;
    case (dir_r)
      2'd0: begin nb_ok = row_r != '0; nb_addr = cell_r - AW'(n_r); end
      2'd1: begin nb_ok = (row_r + SW'(1)) < n_r; nb_addr = cell_r + AW'(n_r); end
      2'd2: begin nb_ok = col_r != '0; nb_addr = cell_r - AW'(1); end
      2'd3: begin nb_ok = (col_r + SW'(1)) < n_r; nb_addr = cell_r + AW'(1); end
      default: ;
    endcase
  end

  // relaxation compare
  logic [DW-1:0] cand;
  logic          better;
  assign cand   = cdist_r + DW'(w_rd);
  assign better = (d_rd == UNR) || (d_rd > cand);

  always_comb begin
    w_we = cmd.load_wr && (load_pos_r < total_now);
    w_wa = AW'(load_pos_r);
    w_ra = nb_r;
    d_we = 1'b0; d_wa = AW'(clr_r); d_wd = UNR; d_ra = nb_r;
    m_we = 1'b0; m_wa = AW'(clr_r); m_wd = 1'b0; m_ra = nb_r;
    q_we = 1'b0; q_wa = q_tail_r; q_wd = '0;
    if (cmd.clr_step) begin d_we = 1'b1; m_we = 1'b1; end
    if (cmd.seed) begin
      d_we = 1'b1; d_wa = '0; d_wd = '0;
      m_we = 1'b1; m_wa = '0; m_wd = 1'b1;
      q_we = 1'b1; q_wa = '0; q_wd = '0;
    end
    if (cmd.pop_take) begin m_we = 1'b1; m_wa = q_rd; m_wd = 1'b0; end
    if (cmd.pop_rd) d_ra = q_rd;
    if (cmd.pop_take) d_ra = q_rd;
    if (cmd.nb_rd) begin w_ra = nb_addr; d_ra = nb_addr; m_ra = nb_addr; end
    if (cmd.nb_upd && better && nb_ok_r) begin
      d_we = 1'b1; d_wa = nb_r; d_wd = cand;
      if (!m_rd) begin
        m_we = 1'b1; m_wa = nb_r; m_wd = 1'b1;
        q_we = 1'b1; q_wd = nb_r;
      end
    end
    if (cmd.fin_rd) d_ra = AW'(total_r - 1'b1);
  end

  assign upd_push = cmd.nb_upd && nb_ok_r && better && !m_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0; q_cnt_r <= '0; q_head_r <= '0; q_tail_r <= '0;
      clr_r <= '0; dir_r <= '0; nb_ok_r <= 1'b0; cd_ld_r <= 1'b0;
    end else begin
      cd_ld_r <= cmd.pop_take;
      if (cmd.load_wr) begin
        if (load_pos_r < total_now) load_pos_r <= load_pos_r + 1'b1;
      end
      if (cmd.clr_start) begin
        clr_r <= '0; n_r <= side_eff; total_r <= total_now;
      end
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.seed) begin
        q_head_r <= '0; q_tail_r <= AW'(1); q_cnt_r <= (AW+1)'(1);
      end
      if (cmd.pop_take) begin
        cell_r <= q_rd;
        q_head_r <= q_head_nxt;
        q_cnt_r <= q_cnt_r - 1'b1;
        dir_r <= '0;
      end
      // popped cell's distance is captured from the registered read in the cycle after the pop
      if (cd_ld_r) cdist_r <= d_rd;
      if (cmd.nb_rd) begin nb_r <= nb_addr; nb_ok_r <= 1'b1; end
      if (cmd.nb_upd) begin
        dir_r <= dir_r + 1'b1; nb_ok_r <= 1'b0;
        if (upd_push) begin
          q_tail_r <= q_tail_nxt; q_cnt_r <= q_cnt_r + 1'b1;
        end
      end
      if (cmd.run_done) load_pos_r <= '0;
    end
  end

  // row/col of popped cell, derived one step per cycle
  logic [AW-1:0] rem_r;
  logic          rc_busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rc_busy_r <= 1'b0;
    else if (cmd.pop_take) begin
      rem_r <= q_rd; row_r <= '0; col_r <= '0; rc_busy_r <= 1'b1;
    end else if (rc_busy_r) begin
      if (rem_r >= AW'(n_r)) begin
        rem_r <= rem_r - AW'(n_r); row_r <= row_r + 1'b1;
      end else begin
        col_r <= SW'(rem_r); rc_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_take) cost_r <= (d_rd > CMAX) ? COST_W'(CMAX) : d_rd[COST_W-1:0];
  end
  assign out_path_cost = cost_r;

  assign sts.clr_last = (clr_r + 1'b1) >= total_r;
  assign sts.q_empty  = q_cnt_r == '0;
  assign sts.rc_busy  = rc_busy_r;
  assign sts.nb_valid = !rc_busy_r && nb_ok;
  assign sts.nb_last  = !rc_busy_r && (dir_r == 2'd3);

  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (AW+1)'(CELLS)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> q_cnt_r != '0) else $error("pop on empty queue");
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_pos_r <= (AW+1)'(CELLS)) else $error("load position overrun");
endmodule
`default_nettype wire

@@ rtl/grid_min_cost_path_core.sv @@
// Cells load one per cycle while the core is in its load state. After the last cell a
// clearing sweep over the n*n cells and a seed step run; each queue pop then reads the
// popped cell, derives row/col by repeated subtraction, reads and relaxes each in-grid
// neighbor, skips each edge side; the result is offered after a pop finds the queue empty.
// One run at a time; the next grid is accepted after the result is taken.
// Reset (rst_n low, synchronous): side register to 1, queue empty, load position zero.
`default_nettype none
module grid_min_cost_path_core
  import gmcp_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WGT_W-1:0]  in_cell_weight,
  input  wire logic              in_last_cell,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [COST_W-1:0]      out_path_cost,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_grid_side
);
  gmcp_cmd_t cmd;
  gmcp_sts_t sts;

  gmcp_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_last_cell, .out_stall, .sts,
    .in_stall, .out_valid, .cfg_ready, .cmd);

  gmcp_dp #(.GRID_MAX(GRID_MAX)) u_dp (.clk, .rst_n, .cfg_we(cfg_valid && cfg_ready),
    .cfg_data(cfg_grid_side), .in_cell_weight, .cmd, .sts, .out_path_cost);
endmodule
`default_nettype wire
